FILE: rtl/u2b_pkg.sv
// Shared types and decode functions for the UTF-8 to BMP code point decoder.
`timescale 1ns / 1ps
package u2b_pkg;

	localparam int unsigned MaxResults = 3;
	localparam int unsigned PendDepth  = 3;
	localparam logic [20:0] BmpMax     = 21'h00FFFF;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_point;
		logic        last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [1:0]                  count;
		logic [MaxResults-1:0][15:0] cp;
	} res_set_t;

	// Sequence length given by a lead byte, 0 for an invalid lead.
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] l;
		unique case (b) inside
			8'b0???????: l = 3'd1;
			8'b110?????: l = 3'd2;
			8'b1110????: l = 3'd3;
			8'b11110???: l = 3'd4;
			default:     l = 3'd0;
		endcase
		return l;
	endfunction

	// Join a lead and its following bytes; w[0] is the lead.
	function automatic logic [20:0] assemble(input logic [3:0][7:0] w, input logic [2:0] l);
		logic [20:0] cp;
		case (l)
			3'd1:    cp = {13'd0, w[0]};
			3'd2:    cp = {10'd0, w[0][4:0], w[1][5:0]};
			3'd3:    cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
			default: cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
		endcase
		return cp;
	endfunction

endpackage

FILE: rtl/u2b_stream_if.sv
// Valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps
interface u2b_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/utf8_to_bmp_codepoint_decoder.sv
// Top level: UTF-8 byte stream in, basic multilingual plane code points out.
`timescale 1ns / 1ps
// A byte passes through the input register and then the result register, which offers its
// first code point. Throughput: one byte per cycle while the output is ready and each byte
// yields at most one code point; a byte that yields more (at most 3) holds the result
// register until the last of them transfers.
// Reset: arst_n clears the input valid, the sequence length and held byte count, and
// the result count; held bytes and payload registers are not cleared.
module utf8_to_bmp_codepoint_decoder import u2b_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	u2b_stream_if.sink   bytes,
	u2b_stream_if.source points
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	logic       consume;
	logic       free;
	res_set_t   res;
	logic [1:0] pend_count;

	// The stage empties into the result register as soon as the previous byte's
	// last code point transfers; a byte can enter every cycle unless stalled.
	assign consume     = valid_s1 && free;
	assign bytes.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	// Hold the payload while stalled; load on every transfer.
	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data.byte_value;
			eos_s1  <= bytes.data.end_of_string;
		end
	end

	// Decode against the held sequence; state advances only on consume.
	u2b_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (consume),
		.byte_value    (byte_s1),
		.end_of_string (eos_s1),
		.res           (res),
		.pend_count    (pend_count)
	);

	// Drain the code points of one byte, one transfer per cycle while the sink is ready.
	u2b_result_buf u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (consume),
		.res    (res),
		.free   (free),
		.points (points)
	);

`ifndef SYNTHESIS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !consume |=> valid_s1 && $stable(byte_s1) && $stable(eos_s1))
		else $error("input stage lost or changed a stalled byte");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		consume && eos_s1 |=> pend_count == 2'd0)
		else $error("end of string left bytes held");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		points.valid && points.ready && points.data.last_of_run && !consume
		|=> !points.valid)
		else $error("result offered after the last of a run");
`endif

endmodule

FILE: rtl/u2b_decode.sv
// Sequence state and single-pass decode of one byte into up to three code points.
`timescale 1ns / 1ps
module u2b_decode import u2b_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] byte_value,
	input  logic       end_of_string,
	output res_set_t   res,
	output logic [1:0] pend_count
);

	logic [PendDepth-1:0][7:0] pend_q;
	logic [1:0]                cnt_q;
	logic [2:0]                slen_q;

	logic [3:0][7:0] buf_w;
	logic [3:0][7:0] win;
	logic [2:0]      len;
	logic [2:0]      l;
	logic [2:0]      idx;
	logic [2:0]      rem;
	logic [20:0]     cp;
	logic [1:0]      n;
	logic            pend_we;
	logic [1:0]      pend_idx;
	logic [1:0]      cnt_d;
	logic [2:0]      slen_d;

	always_comb begin
		for (int k = 0; k < PendDepth; k++) begin
			buf_w[k] = (3'(k) < {1'b0, cnt_q}) ? pend_q[k] : byte_value;
		end
		buf_w[3] = byte_value;
		len      = {1'b0, cnt_q} + 3'd1;
		res      = '0;
		n        = 2'd0;
		idx      = 3'd0;
		win      = buf_w;
		l        = 3'd0;
		rem      = 3'd0;
		cp       = '0;
		pend_we  = 1'b0;
		pend_idx = cnt_q;
		cnt_d    = cnt_q;
		slen_d   = slen_q;

		if (end_of_string) begin
			// Rescan held bytes and this byte as a complete string.
			for (int p = 0; p < 4; p++) begin
				if (idx == 3'(p) && 3'(p) < len) begin
					win = buf_w >> (8 * p);
					l   = lead_len(win[0]);
					rem = len - 3'(p);
					if (l != 3'd0 && l <= rem) begin
						cp = assemble(win, l);
						if (cp <= BmpMax && n != 2'd3) begin
							res.cp[n] = cp[15:0];
							n         = n + 2'd1;
						end
						idx = 3'(p) + l;
					end else begin
						idx = 3'(p) + 3'd1;
					end
				end
			end
			cnt_d  = 2'd0;
			slen_d = 3'd0;
		end else if (cnt_q == 2'd0) begin
			l = lead_len(byte_value);
			if (l == 3'd1) begin
				res.cp[0] = {8'd0, byte_value};
				n         = 2'd1;
			end else if (l != 3'd0) begin
				pend_we  = 1'b1;
				pend_idx = 2'd0;
				cnt_d    = 2'd1;
				slen_d   = l;
			end
		end else if (len >= slen_q) begin
			cp = assemble(buf_w, len);
			if (cp <= BmpMax) begin
				res.cp[0] = cp[15:0];
				n         = 2'd1;
			end
			cnt_d  = 2'd0;
			slen_d = 3'd0;
		end else begin
			pend_we = 1'b1;
			cnt_d   = cnt_q + 2'd1;
		end
		res.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			slen_q <= 3'd0;
		end else if (take) begin
			cnt_q  <= cnt_d;
			slen_q <= slen_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take && pend_we) begin
			pend_q[pend_idx] <= byte_value;
		end
	end

	assign pend_count = cnt_q;

endmodule

FILE: rtl/u2b_result_buf.sv
// Result register set that hands out the code points of one byte one per cycle while the sink is ready.
`timescale 1ns / 1ps
module u2b_result_buf import u2b_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  res_set_t            res,
	output logic                free,
	u2b_stream_if.source        points
);

	logic [MaxResults-1:0][15:0] cp_q;
	logic [1:0]                  n_q;
	logic [1:0]                  rd_q;
	logic                        pending;
	logic                        is_last;
	logic                        xfer;

	assign pending = rd_q < n_q;
	assign is_last = rd_q == (n_q - 2'd1);
	assign xfer    = points.valid && points.ready;
	assign free    = !pending || (xfer && is_last);

	assign points.valid            = pending;
	assign points.data.code_point  = cp_q[(rd_q == 2'd3) ? 2'd0 : rd_q];
	assign points.data.last_of_run = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q  <= 2'd0;
			rd_q <= 2'd0;
		end else if (load) begin
			n_q  <= res.count;
			rd_q <= 2'd0;
		end else if (xfer) begin
			rd_q <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q <= res.cp;
		end
	end

endmodule
